### sv/kte_pkg.sv
// Shared types, constants and codes of the key and timer event generator.
package kte_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIMER_COUNT_DEF = 2;
    localparam int KEY_COUNT_DEF   = 4;

    localparam int CODE_W     = 4;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int DROP_W     = 4;
    localparam int LEVEL_W    = 5;

    localparam logic [7:0]  DEBOUNCE_RST = 8'd3;
    localparam logic [15:0] LONG_RST     = 16'd100;

    localparam logic [CODE_W-1:0] EV_LONG_BASE  = 4'd4;
    localparam logic [CODE_W-1:0] EV_TIMER_BASE = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 8'd1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_POP
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYS,
        ST_TIMERS,
        ST_CTRL,
        ST_POP,
        ST_POP_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              vld;
        logic [CODE_W-1:0] code;
    } t_push;

    typedef struct packed {
        logic             is_timer;
        logic [IDX_W-1:0] idx;
        logic             now;
        logic             stable;
        logic [7:0]       chatter;
        logic [15:0]      hold;
        logic             enabled;
        logic             reload;
        logic [15:0]      elapsed;
        logic [15:0]      limit;
        logic [7:0]       debounce;
        logic [15:0]      long_press;
    } t_elem_in;

    typedef struct packed {
        logic        stable;
        logic [7:0]  chatter;
        logic [15:0] hold;
        logic        enabled;
        logic [15:0] elapsed;
        t_push       push;
    } t_elem_out;

endpackage

### sv/kte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kte_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/kte_elem_unit.sv
// Shared update unit: debounces one key or advances one timer per cycle.
module kte_elem_unit (
    input  kte_pkg::t_elem_in  i_elem,
    output kte_pkg::t_elem_out o_elem
);

    logic        lvl_diff;
    logic [7:0]  chatter_inc;
    logic        accept;
    logic [15:0] op_val;
    logic [15:0] op_ref;
    logic        inc_ok;
    logic [15:0] val_n;
    logic [16:0] diff;
    logic        eq;
    logic        ge;

    always_comb begin
        lvl_diff    = i_elem.now != i_elem.stable;
        chatter_inc = (i_elem.chatter != 8'hFF) ? i_elem.chatter + 8'd1 : i_elem.chatter;
        accept      = lvl_diff && (chatter_inc >= i_elem.debounce);

        op_val = i_elem.is_timer ? i_elem.elapsed : i_elem.hold;
        op_ref = i_elem.is_timer ? i_elem.limit : i_elem.long_press;
        inc_ok = i_elem.is_timer || (i_elem.hold <= i_elem.long_press);
        val_n  = (inc_ok && (op_val != 16'hFFFF)) ? op_val + 16'd1 : op_val;
        diff   = {1'b0, val_n} - {1'b0, op_ref};
        eq     = diff == 17'd0;
        ge     = !diff[16];

        o_elem.stable    = accept ? i_elem.now : i_elem.stable;
        o_elem.chatter   = lvl_diff ? chatter_inc : 8'd0;
        o_elem.hold      = i_elem.hold;
        o_elem.enabled   = i_elem.enabled;
        o_elem.elapsed   = i_elem.elapsed;
        o_elem.push.vld  = 1'b0;
        o_elem.push.code = '0;

        if (i_elem.is_timer) begin
            if (i_elem.enabled) begin
                if (ge) begin
                    o_elem.push.vld  = 1'b1;
                    o_elem.push.code = kte_pkg::EV_TIMER_BASE
                                     + kte_pkg::CODE_W'(i_elem.idx);
                    o_elem.elapsed   = 16'd0;
                    o_elem.enabled   = i_elem.reload;
                end else begin
                    o_elem.elapsed = val_n;
                end
            end
        end else if (accept) begin
            o_elem.push.vld  = !i_elem.now;
            o_elem.push.code = kte_pkg::CODE_W'(i_elem.idx);
        end else if (i_elem.stable) begin
            o_elem.hold      = val_n;
            o_elem.push.vld  = eq;
            o_elem.push.code = kte_pkg::EV_LONG_BASE + kte_pkg::CODE_W'(i_elem.idx);
        end else begin
            o_elem.hold = 16'd0;
        end
    end

endmodule

### sv/kte_event_queue.sv
// Event FIFO: pointers, fill count, drop counter and the event store.
module kte_event_queue #(
    parameter int QUEUE_DEPTH = kte_pkg::QUEUE_DEPTH_DEF,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1),
    localparam int PW         = $clog2(QUEUE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kte_pkg::t_push                i_push,
    input  logic                          i_pop,
    input  logic                          i_clear_drops,
    output logic [CW-1:0]                 o_count,
    output logic                          o_empty,
    output logic [kte_pkg::DROP_W-1:0]    o_drops,
    output logic [kte_pkg::CODE_W-1:0]    o_rd_code
);

    logic [PW-1:0]              r_wptr;
    logic [PW-1:0]              n_wptr;
    logic [PW-1:0]              r_rptr;
    logic [PW-1:0]              n_rptr;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [kte_pkg::DROP_W-1:0] r_drops;
    logic [kte_pkg::DROP_W-1:0] n_drops;
    logic                       full;
    logic                       wr;

    always_comb begin
        full   = r_count == CW'(QUEUE_DEPTH);
        wr     = i_push.vld && !full;
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (wr) begin
            n_wptr = (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        unique case ({wr, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
        if (i_clear_drops) begin
            n_drops = '0;
        end else if (i_push.vld && full) begin
            n_drops = r_drops + kte_pkg::DROP_W'(1);
        end else begin
            n_drops = r_drops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_drops <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
            r_drops <= n_drops;
        end
    end

    kte_ram #(
        .WIDTH (kte_pkg::CODE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (r_wptr),
        .i_wdata (i_push.code),
        .i_re    (i_pop),
        .i_raddr (r_rptr),
        .o_rdata (o_rd_code)
    );

    assign o_count = r_count;
    assign o_empty = r_count == '0;
    assign o_drops = r_drops;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_drop_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld && full && !i_clear_drops |=> r_drops == $past(r_drops) + 1'b1)
        else $error("full push not counted as drop");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld && !full && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not raise count");

endmodule

### sv/key_and_timer_event_generator_unit.sv
// Top level: key debouncer and timer event generator with event FIFO.
// Tick: keys then timers visited one per cycle through one shared update unit;
//   result loaded from ST_DONE once the output register is free; no new item
//   is accepted until the sequencer is back in ST_IDLE.
// Start/stop: timer state written in ST_CTRL, result loaded from ST_DONE; one item at a time.
// Pop: the registered store read is taken in ST_POP_WAIT, which an empty queue skips.
// Reset (synchronous, active low): keys released, timers disabled, FIFO empty, config 3/100.
module key_and_timer_event_generator_unit #(
    parameter int QUEUE_DEPTH = kte_pkg::QUEUE_DEPTH_DEF,
    parameter int TIMER_COUNT = kte_pkg::TIMER_COUNT_DEF,
    parameter int KEY_COUNT   = kte_pkg::KEY_COUNT_DEF,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1),
    localparam int KW         = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1,
    localparam int TW         = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // key_levels[3:0], timer_index[6:4], timer_period[22:7], timer_cyclic[23]
    input  logic [23:0]                       s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // event_code[3:0], queue_level[8:4], dropped[12:9], zero[15:13]
    output logic [15:0]                       m_axis_tdata,
    // event_valid[0]
    output logic                              m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kte_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kte_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    kte_pkg::t_state r_state;
    kte_pkg::t_state n_state;
    logic [kte_pkg::IDX_W-1:0] r_idx;
    logic [kte_pkg::IDX_W-1:0] n_idx;

    kte_pkg::t_op r_op;
    logic [3:0]   r_levels;
    logic [2:0]   r_tidx;
    logic [15:0]  r_period;
    logic         r_cyclic;

    logic [7:0]  r_debounce;
    logic [15:0] r_long;

    logic        r_key_stable [KEY_COUNT];
    logic [7:0]  r_chatter    [KEY_COUNT];
    logic [15:0] r_hold       [KEY_COUNT];
    logic        r_tmr_en     [TIMER_COUNT];
    logic        r_tmr_reload [TIMER_COUNT];
    logic [15:0] r_tmr_elapsed[TIMER_COUNT];
    logic [15:0] r_tmr_limit  [TIMER_COUNT];

    logic                       r_hit;
    logic [kte_pkg::CODE_W-1:0] r_code;
    logic                       r_m_valid;
    logic                       r_m_user;
    logic [15:0]                r_m_data;

    logic                       s_accept;
    logic                       key_we;
    logic                       tmr_we;
    logic                       ctrl_we;
    logic                       q_pop;
    logic                       clear_drops;
    logic                       load_out;
    logic                       tidx_ok;
    logic [KW-1:0]              kidx;
    logic [TW-1:0]              tsel;
    logic [TW-1:0]              csel;
    kte_pkg::t_elem_in          elem_in;
    kte_pkg::t_elem_out         elem_out;
    kte_pkg::t_push             q_push;
    logic [CW-1:0]              q_count;
    logic                       q_empty;
    logic [kte_pkg::DROP_W-1:0] q_drops;
    logic [kte_pkg::CODE_W-1:0] q_rd_code;

    assign s_accept    = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign kidx        = r_idx[KW-1:0];
    assign tsel        = r_idx[TW-1:0];
    assign csel        = r_tidx[TW-1:0];
    assign tidx_ok     = {1'b0, r_tidx} < 4'(TIMER_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= kte_pkg::DEBOUNCE_RST;
            r_long     <= kte_pkg::LONG_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == kte_pkg::CFG_DEBOUNCE) begin
                r_debounce <= i_cfg_data[7:0];
            end else if (i_cfg_index == kte_pkg::CFG_LONG) begin
                r_long <= i_cfg_data[15:0];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        s_axis_tready = 1'b0;
        key_we      = 1'b0;
        tmr_we      = 1'b0;
        ctrl_we     = 1'b0;
        q_pop       = 1'b0;
        clear_drops = 1'b0;
        load_out    = 1'b0;
        unique case (r_state)
            kte_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    clear_drops = 1'b1;
                    n_idx       = '0;
                    unique case (kte_pkg::t_op'(s_axis_tuser))
                        kte_pkg::OP_TICK:  n_state = kte_pkg::ST_KEYS;
                        kte_pkg::OP_START: n_state = kte_pkg::ST_CTRL;
                        kte_pkg::OP_STOP:  n_state = kte_pkg::ST_CTRL;
                        kte_pkg::OP_POP:   n_state = kte_pkg::ST_POP;
                        default:           n_state = kte_pkg::ST_IDLE;
                    endcase
                end
            end
            kte_pkg::ST_KEYS: begin
                key_we = 1'b1;
                if (r_idx == kte_pkg::IDX_W'(KEY_COUNT - 1)) begin
                    n_idx   = '0;
                    n_state = kte_pkg::ST_TIMERS;
                end else begin
                    n_idx = r_idx + kte_pkg::IDX_W'(1);
                end
            end
            kte_pkg::ST_TIMERS: begin
                tmr_we = 1'b1;
                if (r_idx == kte_pkg::IDX_W'(TIMER_COUNT - 1)) begin
                    n_idx   = '0;
                    n_state = kte_pkg::ST_DONE;
                end else begin
                    n_idx = r_idx + kte_pkg::IDX_W'(1);
                end
            end
            kte_pkg::ST_CTRL: begin
                ctrl_we = 1'b1;
                n_state = kte_pkg::ST_DONE;
            end
            kte_pkg::ST_POP: begin
                if (!q_empty) begin
                    q_pop   = 1'b1;
                    n_state = kte_pkg::ST_POP_WAIT;
                end else begin
                    n_state = kte_pkg::ST_DONE;
                end
            end
            kte_pkg::ST_POP_WAIT: begin
                n_state = kte_pkg::ST_DONE;
            end
            kte_pkg::ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = kte_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kte_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op     <= kte_pkg::t_op'(s_axis_tuser);
            r_levels <= s_axis_tdata[3:0];
            r_tidx   <= s_axis_tdata[6:4];
            r_period <= s_axis_tdata[22:7];
            r_cyclic <= s_axis_tdata[23];
        end
    end

    always_comb begin
        elem_in.is_timer   = r_state == kte_pkg::ST_TIMERS;
        elem_in.idx        = r_idx;
        elem_in.now        = !r_levels[kidx];
        elem_in.stable     = r_key_stable[kidx];
        elem_in.chatter    = r_chatter[kidx];
        elem_in.hold       = r_hold[kidx];
        elem_in.enabled    = r_tmr_en[tsel];
        elem_in.reload     = r_tmr_reload[tsel];
        elem_in.elapsed    = r_tmr_elapsed[tsel];
        elem_in.limit      = r_tmr_limit[tsel];
        elem_in.debounce   = r_debounce;
        elem_in.long_press = r_long;
    end

    kte_elem_unit u_elem (
        .i_elem (elem_in),
        .o_elem (elem_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_key_stable[k] <= 1'b0;
                r_chatter[k]    <= 8'd0;
                r_hold[k]       <= 16'd0;
            end
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_tmr_en[t]      <= 1'b0;
                r_tmr_reload[t]  <= 1'b0;
                r_tmr_elapsed[t] <= 16'd0;
                r_tmr_limit[t]   <= 16'd0;
            end
        end else begin
            if (key_we) begin
                r_key_stable[kidx] <= elem_out.stable;
                r_chatter[kidx]    <= elem_out.chatter;
                r_hold[kidx]       <= elem_out.hold;
            end
            if (tmr_we) begin
                r_tmr_en[tsel]      <= elem_out.enabled;
                r_tmr_elapsed[tsel] <= elem_out.elapsed;
            end
            if (ctrl_we && tidx_ok) begin
                if (r_op == kte_pkg::OP_START) begin
                    r_tmr_en[csel]      <= 1'b1;
                    r_tmr_elapsed[csel] <= 16'd0;
                    r_tmr_limit[csel]   <= r_period;
                    r_tmr_reload[csel]  <= r_cyclic;
                end else if (r_op == kte_pkg::OP_STOP) begin
                    r_tmr_en[csel] <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        q_push.vld  = (key_we || tmr_we) && elem_out.push.vld;
        q_push.code = elem_out.push.code;
    end

    kte_event_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (q_push),
        .i_pop         (q_pop),
        .i_clear_drops (clear_drops),
        .o_count       (q_count),
        .o_empty       (q_empty),
        .o_drops       (q_drops),
        .o_rd_code     (q_rd_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (s_accept) begin
            r_hit <= 1'b0;
        end else if (r_state == kte_pkg::ST_POP_WAIT) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_code <= '0;
        end else if (r_state == kte_pkg::ST_POP_WAIT) begin
            r_code <= q_rd_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_user <= r_hit;
            r_m_data <= {3'b000, q_drops, kte_pkg::LEVEL_W'(q_count), r_code};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tdata  = r_m_data;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_state != kte_pkg::ST_IDLE)
        else $error("sequencer stayed idle after accept");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == kte_pkg::ST_DONE))
        else $error("result raised outside completion");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kte_pkg::ST_POP_WAIT |-> $past(!q_empty))
        else $error("store read issued on empty queue");

endmodule

### verif/tb.sv
// Self-checking testbench: drives key, timer and pop items and predicts every event result.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS            = kte_pkg::KEY_COUNT_DEF;
    localparam int TIMERS          = kte_pkg::TIMER_COUNT_DEF;
    localparam int QDEPTH          = kte_pkg::QUEUE_DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 12;

    localparam logic [kte_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 8'd2;
    localparam logic [kte_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 8'hFF;

    typedef struct packed {
        logic                        vld;
        logic [kte_pkg::CODE_W-1:0]  code;
        logic [kte_pkg::LEVEL_W-1:0] level;
        logic [kte_pkg::DROP_W-1:0]  drops;
    } t_event_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [kte_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [kte_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    always #6 i_clk = ~i_clk;

    key_and_timer_event_generator_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // key and timer state as the block should hold it
    logic [7:0]  cfg_debounce;
    logic [15:0] cfg_long;
    logic        key_down    [KEYS];
    logic [7:0]  key_chatter [KEYS];
    logic [15:0] key_hold    [KEYS];
    logic        tmr_on      [TIMERS];
    logic        tmr_cyclic  [TIMERS];
    logic [15:0] tmr_count   [TIMERS];
    logic [15:0] tmr_period  [TIMERS];
    logic [kte_pkg::CODE_W-1:0] event_fifo[$];
    int          drops_this_step;

    t_event_result expected_events[$];
    int mismatches = 0;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int hold_off_asked = 0;
    int hold_off_done  = 0;
    int sink_wait      = 0;
    int quiet_cycles   = 0;

    logic [3:0] key_pattern = 4'hF;
    int         key_run_left = 0;
    int         run_span = 8;

    function automatic void reset_key_timer_state();
        cfg_debounce = kte_pkg::DEBOUNCE_RST;
        cfg_long     = kte_pkg::LONG_RST;
        for (int k = 0; k < KEYS; k++) begin
            key_down[k]    = 1'b0;
            key_chatter[k] = '0;
            key_hold[k]    = '0;
        end
        for (int t = 0; t < TIMERS; t++) begin
            tmr_on[t]     = 1'b0;
            tmr_cyclic[t] = 1'b0;
            tmr_count[t]  = '0;
            tmr_period[t] = '0;
        end
        event_fifo.delete();
    endfunction

    function automatic void queue_event(logic [kte_pkg::CODE_W-1:0] code);
        if (event_fifo.size() >= QDEPTH)
            drops_this_step++;
        else
            event_fifo.push_back(code);
    endfunction

    function automatic void debounce_key(int k, logic [3:0] levels);
        logic now_down;
        logic accepted;
        now_down = ~levels[k];
        accepted = 1'b0;
        if (now_down == key_down[k]) begin
            key_chatter[k] = '0;
        end else begin
            if (key_chatter[k] != 8'hFF)
                key_chatter[k]++;
            if (key_chatter[k] >= cfg_debounce) begin
                key_down[k] = now_down;
                accepted = 1'b1;
            end
        end
        if (accepted) begin
            if (!key_down[k])
                queue_event(kte_pkg::CODE_W'(k));
        end else if (key_down[k]) begin
            if (key_hold[k] <= cfg_long && key_hold[k] != 16'hFFFF)
                key_hold[k]++;
            if (key_hold[k] == cfg_long)
                queue_event(kte_pkg::EV_LONG_BASE + kte_pkg::CODE_W'(k));
        end else begin
            key_hold[k] = '0;
        end
    endfunction

    function automatic void advance_timer(int t);
        if (tmr_on[t]) begin
            if (tmr_count[t] != 16'hFFFF)
                tmr_count[t]++;
            if (tmr_count[t] >= tmr_period[t]) begin
                queue_event(kte_pkg::EV_TIMER_BASE + kte_pkg::CODE_W'(t));
                tmr_count[t] = '0;
                tmr_on[t] = tmr_cyclic[t];
            end
        end
    endfunction

    function automatic t_event_result advance_event_generator(kte_pkg::t_op op,
            logic [3:0] levels, logic [2:0] idx, logic [15:0] period, logic cyc);
        t_event_result r;
        r = '0;
        drops_this_step = 0;
        case (op)
            kte_pkg::OP_TICK: begin
                for (int k = 0; k < KEYS; k++)
                    debounce_key(k, levels);
                for (int t = 0; t < TIMERS; t++)
                    advance_timer(t);
            end
            kte_pkg::OP_START: begin
                if (idx < TIMERS) begin
                    tmr_on[idx]     = 1'b1;
                    tmr_count[idx]  = '0;
                    tmr_period[idx] = period;
                    tmr_cyclic[idx] = cyc;
                end
            end
            kte_pkg::OP_STOP: begin
                if (idx < TIMERS)
                    tmr_on[idx] = 1'b0;
            end
            default: begin
                if (event_fifo.size() != 0) begin
                    r.vld  = 1'b1;
                    r.code = event_fifo.pop_front();
                end
            end
        endcase
        r.level = kte_pkg::LEVEL_W'(event_fifo.size());
        r.drops = kte_pkg::DROP_W'(drops_this_step);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // predict on each accepted item, then check each accepted result
    always @(posedge i_clk) begin : scoreboard
        t_event_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == kte_pkg::CFG_DEBOUNCE)
                    cfg_debounce = i_cfg_data[7:0];
                else if (i_cfg_index == kte_pkg::CFG_LONG)
                    cfg_long = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_events.push_back(advance_event_generator(
                    kte_pkg::t_op'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[6:4],
                    s_axis_tdata[22:7], s_axis_tdata[23]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    $error("result item with none expected: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_axis_tuser !== want.vld) begin
                        $error("event_valid: expected %0d, got %0d", want.vld, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[3:0] !== want.code) begin
                        $error("event_code: expected %0d, got %0d", want.code,
                               m_axis_tdata[3:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[8:4] !== want.level) begin
                        $error("queue_level: expected %0d, got %0d", want.level,
                               m_axis_tdata[8:4]);
                        mismatches++;
                    end
                    if (m_axis_tdata[12:9] !== want.drops) begin
                        $error("dropped: expected %0d, got %0d", want.drops,
                               m_axis_tdata[12:9]);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait <= 0;
        end else if (hold_off_done != hold_off_asked) begin
            hold_off_done <= hold_off_asked;
            sink_wait <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
            sink_wait <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_item(kte_pkg::t_op op, logic [3:0] levels, logic [2:0] idx,
            logic [15:0] period, logic cyc);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {cyc, period, idx, levels};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic tick(logic [3:0] levels);
        send_item(kte_pkg::OP_TICK, levels, 3'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic start_timer(logic [2:0] idx, logic [15:0] period, logic cyc);
        send_item(kte_pkg::OP_START, 4'($urandom), idx, period, cyc);
    endtask

    task automatic stop_timer(logic [2:0] idx);
        send_item(kte_pkg::OP_STOP, 4'($urandom), idx, 16'($urandom), 1'($urandom));
    endtask

    task automatic pop_event();
        send_item(kte_pkg::OP_POP, 4'($urandom), 3'($urandom), 16'($urandom),
                  1'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_events.size() != 0);
    endtask

    task automatic write_reg(logic [kte_pkg::CFG_IDX_W-1:0] index,
            logic [kte_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(logic [15:0] deb_data, logic [15:0] long_data);
        int span;
        write_reg(kte_pkg::CFG_DEBOUNCE, deb_data);
        write_reg(kte_pkg::CFG_LONG, long_data);
        i_cfg_valid <= 1'b0;
        span = int'(deb_data[7:0]) + int'(long_data) + 4;
        run_span = (span > 40) ? 40 : span;
    endtask

    // hold key patterns for runs so they pass debounce, with the odd glitch
    task automatic random_item(int pop_weight);
        int r;
        logic [3:0] levels;
        r = $urandom_range(0, 99);
        if (r < pop_weight) begin
            pop_event();
        end else if (r < pop_weight + 8) begin
            start_timer(($urandom_range(0, 3) == 0) ? 3'($urandom_range(2, 7))
                                                    : 3'($urandom_range(0, 1)),
                        ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 12)),
                        1'($urandom));
        end else if (r < pop_weight + 12) begin
            stop_timer(3'($urandom));
        end else begin
            if (key_run_left == 0) begin
                key_pattern  = 4'($urandom_range(0, 15));
                key_run_left = $urandom_range(1, run_span);
            end
            if ($urandom_range(0, 9) == 0) begin
                levels = 4'($urandom);
            end else begin
                levels = key_pattern;
                key_run_left--;
            end
            tick(levels);
        end
    endtask

    task automatic test_directed_basics();
        pop_event();
        start_timer(3'd0, 16'd0, 1'b1);
        start_timer(3'd7, 16'hFFFF, 1'b1);
        start_timer(3'd1, 16'd2, 1'b0);
        tick(4'hF);
        tick(4'hF);
        tick(4'h0);
        tick(4'hA);
        tick(4'h0);
        tick(4'h0);
        tick(4'h0);
        stop_timer(3'd0);
        stop_timer(3'd6);
        tick(4'h0);
        tick(4'hF);
        tick(4'hF);
        tick(4'hF);
        repeat (8) pop_event();
        drain();
    endtask

    task automatic test_zero_settings();
        configure(16'hFF00, 16'd0);
        tick(4'hE);
        repeat (3) tick(4'hE);
        tick(4'hF);
        tick(4'h7);
        tick(4'hF);
        repeat (3) pop_event();
        drain();
    endtask

    task automatic test_long_press();
        configure(16'd1, 16'd3);
        repeat (6) tick(4'h0);
        tick(4'hF);
        tick(4'hF);
        repeat (9) pop_event();
        drain();
    endtask

    task automatic test_queue_overflow();
        configure(16'd2, 16'd4);
        start_timer(3'd0, 16'd0, 1'b1);
        start_timer(3'd1, 16'd0, 1'b1);
        repeat (12) tick(4'h0);
        repeat (3) tick(4'hF);
        stop_timer(3'd0);
        stop_timer(3'd1);
        repeat (QDEPTH + 1) pop_event();
        drain();
    endtask

    task automatic test_backpressure();
        configure(16'd1, 16'd6);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_off_asked++;
        repeat (48) random_item(25);
        drain();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_register_extremes();
        configure(16'hFFFF, 16'hFFFE);
        repeat (60) random_item(25);
        drain();
        write_reg(kte_pkg::CFG_LONG, 16'hFFFF);
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
        i_cfg_valid <= 1'b0;
        repeat (60) random_item(25);
        drain();
    endtask

    task automatic test_random_phase(logic [15:0] deb_data, logic [15:0] long_data, int n,
            int pop_weight, bit idle);
        configure(deb_data, long_data);
        src_idle_en  = idle;
        sink_idle_en = idle;
        repeat (n) random_item(pop_weight);
        drain();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        reset_key_timer_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_basics();
        test_zero_settings();
        test_long_press();
        test_queue_overflow();
        test_random_phase(16'd2, 16'd10, 200, 30, 1'b1);
        test_random_phase(16'd0, 16'd0, 150, 30, 1'b1);
        test_random_phase(16'd1, 16'd1, 150, 35, 1'b1);
        test_random_phase(16'd5, 16'd30, 200, 10, 1'b1);
        test_backpressure();
        test_register_extremes();
        test_random_phase(16'd1, 16'd20, 150, 30, 1'b0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_events.size() != 0) begin
            $error("%0d expected result items never arrived", expected_events.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
